### rtl/servo_bus_packet_framer_defines.svh
// Assertion macros for the servo bus packet framer checker.
// No dependencies; included by files that carry assertions.
`ifndef SERVO_BUS_PACKET_FRAMER_DEFINES_SVH
`define SERVO_BUS_PACKET_FRAMER_DEFINES_SVH

// Property checked outside reset.
`define SBPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define SBPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/sbpf_pkg.sv
// Shared constants and types for the servo bus packet framer.
// No dependencies; used by the controller, datapath and top level.
package sbpf_pkg;

  localparam int IN_W  = 48;
  localparam int OUT_W = 32;

  localparam logic [2:0] CMD_READ      = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_REG_WRITE = 3'd2;
  localparam logic [2:0] CMD_ACTION    = 3'd3;
  localparam logic [2:0] CMD_RX_BYTE   = 3'd4;

  localparam logic [7:0] INSTR_READ      = 8'h02;
  localparam logic [7:0] INSTR_WRITE     = 8'h03;
  localparam logic [7:0] INSTR_REG_WRITE = 8'h04;
  localparam logic [7:0] INSTR_ACTION    = 8'h05;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [7:0] BCAST_ID = 8'hFE;

  localparam logic [3:0] REPLY_BASE_LEN = 4'd6;
  localparam logic [3:0] ERR_INDEX      = 4'd4;
  localparam logic [3:0] DATA_INDEX     = 4'd5;

  typedef struct packed {
    logic load_req;
    logic take_rx;
    logic emit_tx;
    logic emit_reply;
  } ctl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic pkt_last;
    logic rx_completes;
  } ctl_sts_t;

endpackage

### rtl/servo_bus_packet_framer.sv
// Top level of the servo bus packet framer: controller plus datapath.
// Depends on sbpf_pkg, sbpf_controller and sbpf_datapath.
//
// Input channel: one item is a request (read, write, registered write,
// broadcast action) or one byte received from the bus, selected by in_tuser.
// Output channel: transmit bytes (out_tuser 0, out_tlast on the checksum)
// and completed status replies (out_tuser 1, error and data in out_tdata).
//
// A taken request is stored, then the send state loads its bytes into the
// output register, one byte per cycle while out_tready holds: 8 bytes for
// a read, 8 or 9 for a write, 6 for an action. in_tready stays low until
// the checksum byte is loaded into the output register.
// The byte that completes a reply moves the controller to its reply state,
// which loads the reply result; in_tready stays low until it is loaded.
// The byte sequencer feeds the single output register.
// A stalled receiver holds the output register and the byte sequencer; no
// item is lost. Synchronous reset clears the sequencer, the reply tracker
// and the output valid; no reply is pending afterwards.
module servo_bus_packet_framer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // target_id[7:0], reg_address[15:8], byte_count[17:16],
  // data_word[33:18], rx_byte[41:34], zero fill
  input  logic [sbpf_pkg::IN_W-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [2:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // tx_byte[7:0], status_error[15:8], status_data[31:16]
  output logic [sbpf_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast,
  // kind[0]
  output logic                       out_tuser
);

  sbpf_pkg::ctl_cmd_t ctl;
  sbpf_pkg::ctl_sts_t sts;

  sbpf_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .ctl       (ctl)
  );

  sbpf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_cmd    (in_tuser),
    .req_data   (in_tdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/sbpf_controller.sv
// Sequencing state machine of the servo bus packet framer.
// Depends on sbpf_pkg; drives the datapath through command/status structs.
module sbpf_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,
  input  sbpf_pkg::ctl_sts_t sts,
  output sbpf_pkg::ctl_cmd_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_RPLY = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser inside {sbpf_pkg::CMD_READ, sbpf_pkg::CMD_WRITE,
                               sbpf_pkg::CMD_REG_WRITE, sbpf_pkg::CMD_ACTION}) begin
            ctl.load_req = 1'b1;
            state_nxt    = ST_SEND;
          end else if (in_tuser == sbpf_pkg::CMD_RX_BYTE) begin
            ctl.take_rx = 1'b1;
            if (sts.rx_completes) begin
              state_nxt = ST_RPLY;
            end
          end
        end
      end
      ST_SEND: begin
        ctl.emit_tx = sts.slot_free;
        if (sts.slot_free && sts.pkt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RPLY: begin
        ctl.emit_reply = sts.slot_free;
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/sbpf_datapath.sv
// Packet byte store, checksum, reply capture and output register.
// Depends on sbpf_pkg; commanded by sbpf_controller.
module sbpf_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [2:0]                 req_cmd,
  input  logic [sbpf_pkg::IN_W-1:0]  req_data,
  input  sbpf_pkg::ctl_cmd_t         ctl,
  output sbpf_pkg::ctl_sts_t         sts,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [sbpf_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);

  logic [7:0]  f_id, f_addr, f_rx;
  logic [1:0]  f_cnt, n_sat;
  logic [15:0] f_dw;

  assign f_id   = req_data[7:0];
  assign f_addr = req_data[15:8];
  assign f_cnt  = req_data[17:16];
  assign f_dw   = req_data[33:18];
  assign f_rx   = req_data[41:34];

  always_comb begin
    case (f_cnt)
      2'd0:    n_sat = 2'd1;
      2'd3:    n_sat = 2'd2;
      default: n_sat = f_cnt;
    endcase
  end

  // packet store
  logic [7:0] id_r, len_r, instr_r, p0_r, p1_r, p2_r, sum_r;
  logic [3:0] last_pos_r, pos_r;

  // reply capture
  logic        awaiting_r;
  logic [3:0]  rlen_r, ridx_r;
  logic [7:0]  rerr_r;
  logic [15:0] rdata_r;
  logic [4:0]  ridx_inc;

  // output register
  logic                       out_valid_r;
  logic [sbpf_pkg::OUT_W-1:0] out_data_r;
  logic                       out_last_r, out_user_r;

  logic [7:0] tx_sel;

  assign ridx_inc = {1'b0, ridx_r} + 5'd1;

  assign sts.slot_free    = !out_valid_r || out_tready;
  assign sts.pkt_last     = (pos_r == last_pos_r);
  assign sts.rx_completes = awaiting_r && (ridx_inc >= {1'b0, rlen_r});

  always_comb begin
    case (pos_r)
      4'd0, 4'd1: tx_sel = sbpf_pkg::HDR_BYTE;
      4'd2:       tx_sel = id_r;
      4'd3:       tx_sel = len_r;
      4'd4:       tx_sel = instr_r;
      4'd5:       tx_sel = p0_r;
      4'd6:       tx_sel = p1_r;
      4'd7:       tx_sel = p2_r;
      default:    tx_sel = 8'h00;
    endcase
    if (sts.pkt_last) begin
      tx_sel = ~sum_r;
    end
  end

  // request fields and running checksum
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      p0_r  <= f_addr;
      p2_r  <= f_dw[15:8];
      sum_r <= 8'h00;
      case (req_cmd)
        sbpf_pkg::CMD_READ: begin
          id_r       <= f_id;
          len_r      <= 8'd4;
          instr_r    <= sbpf_pkg::INSTR_READ;
          p1_r       <= {6'd0, n_sat};
          last_pos_r <= 4'd7;
        end
        sbpf_pkg::CMD_WRITE, sbpf_pkg::CMD_REG_WRITE: begin
          id_r       <= f_id;
          len_r      <= 8'd3 + {6'd0, n_sat};
          instr_r    <= (req_cmd == sbpf_pkg::CMD_WRITE) ? sbpf_pkg::INSTR_WRITE
                                                        : sbpf_pkg::INSTR_REG_WRITE;
          p1_r       <= f_dw[7:0];
          last_pos_r <= 4'd6 + {2'd0, n_sat};
        end
        default: begin
          id_r       <= sbpf_pkg::BCAST_ID;
          len_r      <= 8'd2;
          instr_r    <= sbpf_pkg::INSTR_ACTION;
          p1_r       <= f_dw[7:0];
          last_pos_r <= 4'd5;
        end
      endcase
    end else if (ctl.emit_tx && pos_r >= 4'd2 && !sts.pkt_last) begin
      sum_r <= sum_r + tx_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 4'd0;
      awaiting_r <= 1'b0;
      rlen_r     <= 4'd0;
      ridx_r     <= 4'd0;
      rerr_r     <= 8'h00;
      rdata_r    <= 16'h0000;
    end else if (ctl.load_req) begin
      pos_r  <= 4'd0;
      ridx_r <= 4'd0;
      if (req_cmd == sbpf_pkg::CMD_ACTION) begin
        awaiting_r <= 1'b0;
      end else begin
        awaiting_r <= (f_id != sbpf_pkg::BCAST_ID);
        rlen_r     <= (req_cmd == sbpf_pkg::CMD_READ)
                      ? sbpf_pkg::REPLY_BASE_LEN + {2'd0, n_sat}
                      : sbpf_pkg::REPLY_BASE_LEN;
        rerr_r     <= 8'h00;
        rdata_r    <= 16'h0000;
      end
    end else begin
      if (ctl.emit_tx) begin
        pos_r <= pos_r + 4'd1;
      end
      if (ctl.take_rx && awaiting_r) begin
        if (ridx_r == sbpf_pkg::ERR_INDEX) begin
          rerr_r <= f_rx;
        end else if (ridx_r >= sbpf_pkg::DATA_INDEX && ridx_inc < {1'b0, rlen_r}) begin
          if (ridx_r == sbpf_pkg::DATA_INDEX) begin
            rdata_r[7:0] <= f_rx;
          end else begin
            rdata_r[15:8] <= f_rx;
          end
        end
        ridx_r <= ridx_inc[3:0];
        if (sts.rx_completes) begin
          awaiting_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_tx || ctl.emit_reply) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_tx) begin
      out_data_r <= {24'h000000, tx_sel};
      out_last_r <= sts.pkt_last;
      out_user_r <= 1'b0;
    end else if (ctl.emit_reply) begin
      out_data_r <= {rdata_r, rerr_r, 8'h00};
      out_last_r <= 1'b0;
      out_user_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

### rtl/sbpf_checker.sv
// Port-level assertions for the servo bus packet framer, with its bind.
// Depends on sbpf_pkg and servo_bus_packet_framer_defines.svh.
`include "servo_bus_packet_framer_defines.svh"

module sbpf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [sbpf_pkg::OUT_W-1:0] out_tdata,
  input logic                       out_tlast,
  input logic                       out_tuser
);

  `SBPF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "out_tvalid after reset")

  `SBPF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled item changed")

  `SBPF_ASSERT(a_reply_not_last, out_tvalid && out_tuser |-> !out_tlast && out_tdata[7:0] == 8'h00, "reply item malformed")

  `SBPF_ASSERT(a_busy_mid_packet, out_tvalid && !out_tuser && !out_tlast |-> !in_tready, "input taken mid packet")

endmodule

bind servo_bus_packet_framer sbpf_checker u_sbpf_checker (.*);

### sim/tb_servo_bus_packet_framer.sv
// Self-checking testbench for servo_bus_packet_framer: directed table, then random
// request/reply traffic, checked item by item against a behavioral predictor.
// Depends on sbpf_pkg and the servo_bus_packet_framer RTL.
module tb_servo_bus_packet_framer;

  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic       KIND_TX         = 1'b0;
  localparam logic       KIND_REPLY      = 1'b1;
  localparam int         RAND_ITEMS      = 100;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx;
    logic        is_last;
    logic [7:0]  err;
    logic [15:0] data;
  } bus_item_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [7:0]  addr;
    logic [1:0]  bc;
    logic [15:0] dw;
    logic [7:0]  rx;
    logic        n_known;
    logic [3:0]  n;
    logic        ck_known;
    logic [7:0]  ck;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [sbpf_pkg::IN_W-1:0]  in_tdata;
  logic [2:0]                 in_tuser;
  logic                       out_tvalid;
  logic                       out_tready;
  logic [sbpf_pkg::OUT_W-1:0] out_tdata;
  logic                       out_tlast;
  logic                       out_tuser;

  bus_item_t bus_out_q[$];
  int        errors;
  int        live_items;
  int        in_idle_pct;
  int        out_stall_pct;
  int        idle_cycles;

  // reply tracker copy
  logic        reply_pending;
  logic [3:0]  reply_len;
  logic [3:0]  reply_idx;
  logic [7:0]  reply_err;
  logic [15:0] reply_data;

  dir_row_t dir_rows [26] = '{
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd1, 16'h0000, 8'h55, 1'b1, 4'd0, 1'b0, 8'h00},
    '{CMD_SPARE_FIRST,         8'h10, 8'h20, 2'd1, 16'h1234, 8'h00, 1'b1, 4'd0, 1'b0, 8'h00},
    '{CMD_SPARE_LAST,          8'h10, 8'h20, 2'd2, 16'h1234, 8'h00, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_ACTION,    8'h12, 8'h34, 2'd2, 16'h5678, 8'h00, 1'b1, 4'd6, 1'b1, 8'hFA},
    // read, count saturates 3 -> 2, full reply
    '{sbpf_pkg::CMD_READ,      8'h00, 8'h00, 2'd3, 16'h0000, 8'h00, 1'b1, 4'd8, 1'b1, 8'hF7},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h04, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 1'b1, 4'd1, 1'b0, 8'h00},
    // write, count saturates 0 -> 1, reply abandoned by the next request
    '{sbpf_pkg::CMD_WRITE,     8'hFD, 8'hFF, 2'd0, 16'hFFFF, 8'h00, 1'b1, 4'd8, 1'b1, 8'hFD},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_REG_WRITE, 8'hFE, 8'h00, 2'd2, 16'h0000, 8'h00, 1'b1, 4'd9, 1'b1, 8'hF8},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hAA, 1'b1, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_READ,      8'h7F, 8'h80, 2'd1, 16'h0000, 8'h00, 1'b1, 4'd8, 1'b1, 8'hF9},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'hFF, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h7F, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h02, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h80, 1'b0, 4'd0, 1'b0, 8'h00},
    '{sbpf_pkg::CMD_RX_BYTE,   8'h00, 8'h00, 2'd0, 16'h0000, 8'h7D, 1'b0, 4'd0, 1'b0, 8'h00}
  };

  servo_bus_packet_framer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [sbpf_pkg::IN_W-1:0] pack_item(
      input logic [7:0] id, input logic [7:0] addr, input logic [1:0] bc,
      input logic [15:0] dw, input logic [7:0] rx);
    return {6'b0, rx, dw, bc, addr, id};
  endfunction

  function automatic void push_tx(input logic [7:0] b, input logic is_last);
    bus_item_t it;
    it = '{kind: KIND_TX, tx: b, is_last: is_last, err: 8'h00, data: 16'h0000};
    bus_out_q.push_back(it);
  endfunction

  function automatic void frame_packet(input logic [7:0] id, input logic [7:0] instr,
                                       input logic [23:0] prm, input int np);
    logic [7:0] len;
    logic [7:0] sum;
    len = 8'(np + 2);
    sum = id + len + instr;
    push_tx(sbpf_pkg::HDR_BYTE, 1'b0);
    push_tx(sbpf_pkg::HDR_BYTE, 1'b0);
    push_tx(id, 1'b0);
    push_tx(len, 1'b0);
    push_tx(instr, 1'b0);
    for (int i = 0; i < np; i++) begin
      sum = sum + prm[8*i +: 8];
      push_tx(prm[8*i +: 8], 1'b0);
    end
    push_tx(8'hFF - sum, 1'b1);
  endfunction

  // Appends the results that one accepted item causes; returns how many.
  function automatic int frame_predict(input logic [2:0] c,
                                       input logic [sbpf_pkg::IN_W-1:0] d);
    logic [7:0]  id;
    logic [7:0]  addr;
    logic [1:0]  n;
    logic [15:0] dw;
    logic [7:0]  rx;
    logic [7:0]  instr;
    logic [23:0] prm;
    int          np;
    int          first;
    bus_item_t   it;
    first = bus_out_q.size();
    id   = d[7:0];
    addr = d[15:8];
    n    = d[17:16];
    dw   = d[33:18];
    rx   = d[41:34];
    if (n == 2'd0) n = 2'd1;
    if (n == 2'd3) n = 2'd2;
    case (c)
      sbpf_pkg::CMD_READ, sbpf_pkg::CMD_WRITE, sbpf_pkg::CMD_REG_WRITE: begin
        if (c == sbpf_pkg::CMD_READ) begin
          instr = sbpf_pkg::INSTR_READ;
          prm   = {8'h00, 6'b0, n, addr};
          np    = 2;
        end else begin
          instr = (c == sbpf_pkg::CMD_WRITE) ? sbpf_pkg::INSTR_WRITE
                                             : sbpf_pkg::INSTR_REG_WRITE;
          prm   = {dw, addr};
          np    = 1 + int'(n);
        end
        frame_packet(id, instr, prm, np);
        reply_pending = (id != sbpf_pkg::BCAST_ID);
        reply_len     = (c == sbpf_pkg::CMD_READ)
                        ? sbpf_pkg::REPLY_BASE_LEN + {2'b0, n}
                        : sbpf_pkg::REPLY_BASE_LEN;
        reply_idx     = 4'd0;
        reply_err     = 8'h00;
        reply_data    = 16'h0000;
      end
      sbpf_pkg::CMD_ACTION: begin
        reply_pending = 1'b0;
        reply_idx     = 4'd0;
        frame_packet(sbpf_pkg::BCAST_ID, sbpf_pkg::INSTR_ACTION, 24'h0, 0);
      end
      sbpf_pkg::CMD_RX_BYTE: begin
        if (reply_pending) begin
          if (reply_idx == sbpf_pkg::ERR_INDEX) begin
            reply_err = rx;
          end else if (reply_idx >= sbpf_pkg::DATA_INDEX && reply_idx + 4'd1 < reply_len) begin
            if (reply_idx == sbpf_pkg::DATA_INDEX) reply_data[7:0] = rx;
            else reply_data[15:8] = rx;
          end
          reply_idx = reply_idx + 4'd1;
          if (reply_idx >= reply_len) begin
            reply_pending = 1'b0;
            it = '{kind: KIND_REPLY, tx: 8'h00, is_last: 1'b0, err: reply_err, data: reply_data};
            bus_out_q.push_back(it);
          end
        end
      end
      default: ;
    endcase
    return bus_out_q.size() - first;
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [sbpf_pkg::IN_W-1:0] d,
                           output int n_out);
    logic live;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    live = (c <= sbpf_pkg::CMD_ACTION) || (c == sbpf_pkg::CMD_RX_BYTE && reply_pending);
    if (live) live_items++;
    n_out = frame_predict(c, d);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bus_item_t it;
    if (rst_n && out_tvalid && out_tready) begin
      if (bus_out_q.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual tdata %h tlast %b tuser %b",
                 $time, out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        it = bus_out_q.pop_front();
        check_field("kind", 16'(it.kind), 16'(out_tuser));
        check_field("tx_byte", 16'(it.tx), 16'(out_tdata[7:0]));
        check_field("last", 16'(it.is_last), 16'(out_tlast));
        check_field("status_error", 16'(it.err), 16'(out_tdata[15:8]));
        check_field("status_data", it.data, out_tdata[31:16]);
      end
    end
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("[servo_bus_packet_framer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          n_out;
    int          pick;
    int          nrx;
    logic [2:0]  c;
    logic [7:0]  id;
    dir_row_t    row;
    errors        = 0;
    live_items    = 0;
    idle_cycles   = 0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    reply_pending = 1'b0;
    reply_len     = 4'd0;
    reply_idx     = 4'd0;
    reply_err     = 8'h00;
    reply_data    = 16'h0000;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= sbpf_pkg::CMD_READ;
    out_tready <= 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(dir_rows); i++) begin
      row = dir_rows[i];
      send_item(row.cmd, pack_item(row.id, row.addr, row.bc, row.dw, row.rx), n_out);
      if (row.n_known && n_out != int'(row.n)) begin
        $display("%0t: row %0d result count: expected %0d, actual %0d",
                 $time, i, row.n, n_out);
        errors++;
      end
      if (row.ck_known && n_out > 0 && bus_out_q[$].tx != row.ck) begin
        $display("%0t: row %0d checksum: expected %h, actual %h",
                 $time, i, row.ck, bus_out_q[$].tx);
        errors++;
      end
    end

    live_items = 0;
    while (live_items < RAND_ITEMS) begin
      case (live_items / (RAND_ITEMS / 4))
        0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1:       begin in_idle_pct = 64; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 64; end
        default: begin in_idle_pct = 24; out_stall_pct = 24; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        c  = 3'($urandom_range(sbpf_pkg::CMD_READ, sbpf_pkg::CMD_REG_WRITE));
        id = ($urandom_range(0, 9) == 0) ? sbpf_pkg::BCAST_ID : 8'($urandom_range(0, 253));
        send_item(c, pack_item(id, 8'($urandom), 2'($urandom), 16'($urandom), 8'($urandom)),
                  n_out);
        if (reply_pending) begin
          // mostly complete replies, some cut short, some with trailing noise
          nrx = ($urandom_range(0, 9) < 8) ? int'(reply_len)
                                           : $urandom_range(1, int'(reply_len) - 1);
          if ($urandom_range(0, 9) == 0) nrx += 2;
          repeat (nrx) begin
            send_item(sbpf_pkg::CMD_RX_BYTE,
                      pack_item(8'($urandom), 8'($urandom), 2'($urandom),
                                16'($urandom), 8'($urandom)), n_out);
          end
        end
      end else if (pick < 85) begin
        send_item(sbpf_pkg::CMD_ACTION, pack_item(8'($urandom), 8'($urandom), 2'($urandom),
                                                  16'($urandom), 8'($urandom)), n_out);
      end else if (pick < 93) begin
        send_item(sbpf_pkg::CMD_RX_BYTE, pack_item(8'($urandom), 8'($urandom), 2'($urandom),
                                                   16'($urandom), 8'($urandom)), n_out);
      end else begin
        c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        send_item(c, pack_item(8'($urandom), 8'($urandom), 2'($urandom),
                               16'($urandom), 8'($urandom)), n_out);
      end
    end

    in_tvalid <= 1'b0;
    while (bus_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[servo_bus_packet_framer] OK");
    end else begin
      $display("[servo_bus_packet_framer] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sbpf_pkg.sv
rtl/sbpf_controller.sv
rtl/sbpf_datapath.sv
rtl/servo_bus_packet_framer.sv
rtl/sbpf_checker.sv
sim/tb_servo_bus_packet_framer.sv
